@@ rtl/sidt_pkg.sv @@
// Shared types, codes and constant tables for the signed integer to decimal text block.
`default_nettype none

package sidt_pkg;

   localparam int unsigned VALUE_W             = 64;
   localparam int unsigned SPACE_W             = 13;
   localparam int unsigned CHAR_W              = 8;
   localparam int unsigned RADIX               = 10;
   // A 64-bit two's complement magnitude has at most 19 decimal digits.
   localparam int unsigned MAX_DIGITS          = 19;
   localparam int unsigned POS_W               = 5;
   localparam int unsigned LEN_W               = 5;
   localparam int unsigned MULTS               = RADIX - 1;
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FAILED  = 2'd1,
      ST_NO_ROOM = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      writer_ok;
      logic [SPACE_W-1:0]        space_left;
   } req_word_type;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      status_type        status;
      logic              last;
   } rsp_word_type;

   // One classified value waiting for the digit generator.
   typedef struct packed {
      status_type         status;
      logic               neg;
      logic [POS_W-1:0]   top_pos;
      logic [VALUE_W-1:0] mag;
   } job_type;

   typedef logic [MULTS-1:0][VALUE_W-1:0]  mult_row_type;
   typedef mult_row_type [MAX_DIGITS-1:0] mult_table_type;

   // Row p holds 1*10^p through 9*10^p.
   function automatic mult_table_type build_mult_table();
      mult_table_type     t;
      logic [VALUE_W-1:0] p;
      p = 64'd1;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         for (int k = 0; k < MULTS; k++) begin
            t[i][k] = p * VALUE_W'(k + 1);
         end
         p = p * VALUE_W'(RADIX);
      end
      return t;
   endfunction

   localparam mult_table_type MULT_TABLE = build_mult_table();

   function automatic mult_row_type row_for(input logic [POS_W-1:0] pos);
      mult_row_type r;
      r = '0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (pos == POS_W'(i)) begin
            r = MULT_TABLE[i];
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/sidt_front.sv @@
// Front end: takes a value, forms its magnitude and classifies it for the digit generator.
`default_nettype none

module sidt_front import sidt_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire req_word_type req_word,
   output logic              busy,
   output logic              push_valid,
   output job_type           push_job,
   input  wire logic         push_ready
);

   logic               full_ff, full_in;
   logic               neg_ff, neg_in;
   logic               ok_ff, ok_in;
   logic [SPACE_W-1:0] space_ff, space_in;
   logic [VALUE_W-1:0] mag_ff, mag_in;

   logic [MAX_DIGITS-2:0] ge_vec;
   logic [LEN_W-1:0]      digits;
   logic [LEN_W-1:0]      total;
   logic                  accept;

   assign accept = start && !full_ff;

   always_comb begin
      full_in  = full_ff;
      neg_in   = neg_ff;
      ok_in    = ok_ff;
      space_in = space_ff;
      mag_in   = mag_ff;
      if (accept) begin
         full_in  = 1'b1;
         neg_in   = req_word.value[VALUE_W-1];
         ok_in    = req_word.writer_ok;
         space_in = req_word.space_left;
         mag_in   = req_word.value[VALUE_W-1] ? (~req_word.value + VALUE_W'(1))
                                               : req_word.value;
      end else if (push_ready && full_ff) begin
         full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
      neg_ff   <= neg_in;
      ok_ff    <= ok_in;
      space_ff <= space_in;
      mag_ff   <= mag_in;
   end

   // Each compare against a power of ten adds one digit; they are independent.
   always_comb begin
      for (int p = 1; p < MAX_DIGITS; p++) begin
         ge_vec[p-1] = (mag_ff >= MULT_TABLE[p][0]);
      end
   end

   assign digits = LEN_W'(1) + LEN_W'($countones(ge_vec));
   assign total  = digits + LEN_W'(neg_ff);

   always_comb begin
      push_job.neg     = neg_ff;
      push_job.top_pos = POS_W'(digits - LEN_W'(1));
      push_job.mag     = mag_ff;
      if (!ok_ff) begin
         push_job.status = ST_FAILED;
      end else if (space_ff < SPACE_W'(total)) begin
         push_job.status = ST_NO_ROOM;
      end else begin
         push_job.status = ST_OK;
      end
   end

   assign push_valid = full_ff;
   assign busy       = full_ff;

endmodule

`default_nettype wire

@@ rtl/sidt_queue.sv @@
// Short job queue between the front end and the digit generator.
`default_nettype none

module sidt_queue import sidt_pkg::*; #(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   input  wire job_type push_job,
   output logic         push_ready,
   output logic         pop_valid,
   output job_type      pop_job,
   input  wire logic    pop_ready
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   job_type            q_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != CNT_W'(0));
   assign pop_job    = q_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_ready && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

@@ rtl/sidt_back.sv @@
// Digit generator: emits the sign and one decimal digit per cycle, or a single status word.
`default_nettype none

module sidt_back import sidt_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    pop_valid,
   input  wire job_type pop_job,
   output logic         pop_ready,
   output logic         rsp_strobe,
   output rsp_word_type rsp_word
);

   typedef enum logic {
      B_IDLE,
      B_RUN
   } state_type;

   state_type          state_ff, state_in;
   logic               neg_ff, neg_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [VALUE_W-1:0] mag_ff, mag_in;
   mult_row_type       row_ff, row_in;
   logic               strobe_ff, strobe_in;
   rsp_word_type       rsp_ff, rsp_in;

   logic [VALUE_W:0]   diff [MULTS];
   logic [MULTS-1:0]   ge;
   logic [VALUE_W-1:0] rem;
   logic [3:0]         digit;

   // The nine trial subtractions run side by side; the largest one without a borrow wins.
   always_comb begin
      rem = mag_ff;
      for (int k = 0; k < MULTS; k++) begin
         diff[k] = {1'b0, mag_ff} - {1'b0, row_ff[k]};
         ge[k]   = !diff[k][VALUE_W];
         if (ge[k]) begin
            rem = diff[k][VALUE_W-1:0];
         end
      end
   end

   assign digit     = 4'($countones(ge));
   assign pop_ready = (state_ff == B_IDLE);

   always_comb begin
      state_in  = state_ff;
      neg_in    = neg_ff;
      pos_in    = pos_ff;
      mag_in    = mag_ff;
      row_in    = row_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      case (state_ff)
         B_IDLE: begin
            if (pop_valid) begin
               if (pop_job.status != ST_OK) begin
                  strobe_in        = 1'b1;
                  rsp_in.char_code = '0;
                  rsp_in.status    = pop_job.status;
                  rsp_in.last      = 1'b1;
               end else begin
                  state_in = B_RUN;
                  neg_in   = pop_job.neg;
                  pos_in   = pop_job.top_pos;
                  mag_in   = pop_job.mag;
                  row_in   = row_for(pop_job.top_pos);
               end
            end
         end
         B_RUN: begin
            strobe_in     = 1'b1;
            rsp_in.status = ST_OK;
            if (neg_ff) begin
               neg_in           = 1'b0;
               rsp_in.char_code = CHAR_MINUS;
               rsp_in.last      = 1'b0;
            end else begin
               rsp_in.char_code = CHAR_ZERO + CHAR_W'(digit);
               rsp_in.last      = (pos_ff == POS_W'(0));
               mag_in           = rem;
               if (pos_ff == POS_W'(0)) begin
                  state_in = B_IDLE;
               end else begin
                  pos_in = pos_ff - POS_W'(1);
                  row_in = row_for(pos_ff - POS_W'(1));
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      neg_ff <= neg_in;
      pos_ff <= pos_in;
      mag_ff <= mag_in;
      row_ff <= row_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule

`default_nettype wire

@@ rtl/signed_int_to_decimal_text.sv @@
// Top level of the signed 64-bit integer to decimal ASCII text converter.
`default_nettype none

//  Channel   Ports                      Direction  Handshake
//  request   start, busy, req_word      in         word taken when start is high, busy low
//  response  rsp_strobe, rsp_word       out        word valid for the single strobe cycle
//
// The front end registers a taken word, classifies it from that register and hands
// the job to a short queue; it stays busy until the queue takes the job, so it
// takes no new word while it still holds one.
// The digit generator takes a job from the queue while idle and then emits one
// character per cycle (sign first, then digits from the most significant), at most
// 20 characters for a printed value. A status word is registered straight from the
// cycle that takes its job, and the generator stays idle for the next job.
// That one-character-per-cycle loop sets the sustained rate for printed values.
// Reset is synchronous and clears the control state; there is no clearing pass.
// The receiver cannot stall: every response word is taken in its strobe cycle.

module signed_int_to_decimal_text import sidt_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire req_word_type req_word,
   output logic              busy,
   output logic              rsp_strobe,
   output rsp_word_type      rsp_word
);

   // Front end to queue.
   logic    front_push_valid;
   job_type front_job;
   logic    q_push_ready;

   // Queue to digit generator.
   logic    q_pop_valid;
   job_type q_job;
   logic    back_pop_ready;

   // The front end forms the magnitude in unsigned arithmetic, so the most negative
   // value needs no special handling, counts its digits and checks writer and room.
   sidt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_word   (req_word),
      .busy       (busy),
      .push_valid (front_push_valid),
      .push_job   (front_job),
      .push_ready (q_push_ready)
   );

   sidt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_push_valid),
      .push_job   (front_job),
      .push_ready (q_push_ready),
      .pop_valid  (q_pop_valid),
      .pop_job    (q_job),
      .pop_ready  (back_pop_ready)
   );

   // The digit generator strips one decimal digit per cycle against a table of
   // multiples of the current power of ten.
   sidt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (q_pop_valid),
      .pop_job    (q_job),
      .pop_ready  (back_pop_ready),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   // A taken word makes the front end busy while the word is classified.
   a_busy_after_take : assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("front end not busy after taking a word");

   // A full queue holds the classified job in the front end.
   a_hold_when_full : assert property (@(posedge clock) disable iff (reset)
      front_push_valid && !q_push_ready |=> busy && $stable(front_job))
      else $error("classified job lost while the queue was full");

   // A status word stands alone and carries no character.
   a_status_alone : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_word.status != ST_OK |-> rsp_word.last && rsp_word.char_code == '0)
      else $error("status word not final or carries a character");

   // The characters of one value leave in consecutive cycles.
   a_text_unbroken : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_word.status == ST_OK && !rsp_word.last |=> rsp_strobe)
      else $error("gap inside the text of one value");

endmodule

`default_nettype wire

@@ bench/tb_signed_int_to_decimal_text.sv @@
// Self-checking testbench for the signed 64-bit integer to decimal text converter.
`default_nettype none

module tb_signed_int_to_decimal_text;
   import sidt_pkg::*;

   // With the longest sender gaps and the slowest values, the 130 values of a run
   // fit inside this bound many times over.
   localparam int unsigned TIMEOUT_UNITS = 2_000_000;
   localparam int unsigned TAIL_CYCLES   = 30;
   localparam int unsigned RANDOM_VALUES = 107;
   localparam int unsigned PRINT_CAP     = 40;

   // A word waiting to be offered, with the chance (in percent) that the sender
   // sits idle rather than offering it when it could.
   typedef struct {
      req_word_type word;
      int unsigned  idle_pct;
   } pending_type;

   logic         clock    = 1'b0;
   logic         reset    = 1'b1;
   logic         start    = 1'b0;
   req_word_type req_word = '0;
   logic         busy;
   logic         rsp_strobe;
   rsp_word_type rsp_word;

   pending_type  pending_words [$];
   pending_type  next_pending;
   rsp_word_type due_text_words [$];

   int unsigned  mismatch_count = 0;
   int unsigned  values_taken   = 0;
   int unsigned  words_checked  = 0;
   int unsigned  failed_writers = 0;
   int unsigned  no_room_texts  = 0;
   int unsigned  printed_texts  = 0;
   int unsigned  longest_text   = 0;

   signed_int_to_decimal_text uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_word   (req_word),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Every mismatch goes through here. Printing stops after a cap so that a badly
   // broken block cannot flood the log, but the count keeps going.
   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP) begin
         $display("MISMATCH at %0t: %s", $time, what);
      end
   endtask

   // Works out the words that one accepted value must produce and appends them to
   // the queue of words still due. The magnitude is formed in unsigned arithmetic,
   // so the most negative value needs no special handling.
   task automatic predict_decimal_text(input req_word_type w);
      logic [VALUE_W-1:0] mag;
      logic [3:0]         digit_buf [20];
      int                 nd;
      int                 total;
      logic               neg;
      rsp_word_type       r;
      r   = '0;
      neg = w.value[VALUE_W-1];
      mag = w.value;
      if (neg) begin
         mag = ~mag + 64'd1;
      end
      // A failed writer wins over everything else, including a lack of room.
      if (!w.writer_ok) begin
         r.status = ST_FAILED;
         r.last   = 1'b1;
         due_text_words.push_back(r);
         failed_writers++;
         return;
      end
      // Digits are collected least significant first; zero still yields one digit.
      nd = 0;
      do begin
         digit_buf[nd] = 4'(mag % 64'd10);
         mag           = mag / 64'd10;
         nd++;
      end while (mag != 64'd0);
      total = nd + (neg ? 1 : 0);
      // The whole text has to fit; nothing is written in part.
      if (int'(w.space_left) < total) begin
         r.status = ST_NO_ROOM;
         r.last   = 1'b1;
         due_text_words.push_back(r);
         no_room_texts++;
         return;
      end
      printed_texts++;
      if (total > int'(longest_text)) begin
         longest_text = total;
      end
      r.status = ST_OK;
      if (neg) begin
         r.char_code = CHAR_MINUS;
         r.last      = 1'b0;
         due_text_words.push_back(r);
      end
      for (int i = nd - 1; i >= 0; i--) begin
         r.char_code = CHAR_ZERO + CHAR_W'(digit_buf[i]);
         r.last      = (i == 0);
         due_text_words.push_back(r);
      end
   endtask

   task automatic queue_value(input logic signed [VALUE_W-1:0] v, input logic ok,
                              input logic [SPACE_W-1:0] space, input int unsigned idle);
      pending_type p;
      p.word.value      = v;
      p.word.writer_ok  = ok;
      p.word.space_left = space;
      p.idle_pct        = idle;
      pending_words.push_back(p);
   endtask

   // Driver. A word is taken at an edge where start is high and busy is low. At such
   // an edge, or while nothing is on offer, the next word is put up, unless the
   // sender decides to sit idle this cycle. While busy holds a word off, start and
   // the word stay as they are. Each signal gets a single assignment per edge.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (pending_words.size() != 0 &&
             $urandom_range(99, 0) >= pending_words[0].idle_pct) begin
            next_pending = pending_words.pop_front();
            req_word <= next_pending.word;
            start    <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor. The output word is checked first against the oldest word due, and
   // only then is a newly accepted value predicted; a value never answers in the
   // same cycle it is taken, so this order cannot hide a stray output word.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            if (due_text_words.size() == 0) begin
               report_mismatch($sformatf("unexpected word char %h status %0d last %b",
                                         rsp_word.char_code, rsp_word.status,
                                         rsp_word.last));
            end else begin
               if (rsp_word.char_code !== due_text_words[0].char_code) begin
                  report_mismatch($sformatf("char_code got %h want %h",
                                            rsp_word.char_code,
                                            due_text_words[0].char_code));
               end
               if (rsp_word.status !== due_text_words[0].status) begin
                  report_mismatch($sformatf("status got %0d want %0d",
                                            rsp_word.status, due_text_words[0].status));
               end
               if (rsp_word.last !== due_text_words[0].last) begin
                  report_mismatch($sformatf("last got %b want %b",
                                            rsp_word.last, due_text_words[0].last));
               end
               void'(due_text_words.pop_front());
               words_checked++;
            end
         end
         if (start && !busy) begin
            predict_decimal_text(req_word);
            values_taken++;
         end
      end
   end

   // Stimulus, reset and the end of the run.
   initial begin
      logic [VALUE_W-1:0] raw;
      logic               ok;
      logic [SPACE_W-1:0] space;
      int unsigned        sel;
      int unsigned        idle;
      int unsigned        phase_idle [4];

      // Directed part: zero, single digits, the boundaries around ten, the largest
      // and most negative values, texts that fit exactly or miss by one, a failed
      // writer with and without room, and room far above the buffer size.
      queue_value(64'sd0, 1'b1, 13'd8191, 0);
      queue_value(64'sd0, 1'b1, 13'd1, 0);
      queue_value(64'sd0, 1'b1, 13'd0, 0);
      queue_value(64'sd1, 1'b1, 13'd4096, 0);
      queue_value(-64'sd1, 1'b1, 13'd2, 0);
      queue_value(-64'sd1, 1'b1, 13'd1, 0);
      queue_value(64'sd9, 1'b1, 13'd100, 0);
      queue_value(64'sd10, 1'b1, 13'd2, 0);
      queue_value(-64'sd10, 1'b1, 13'd3, 0);
      queue_value(64'sd999999999999999999, 1'b1, 13'd18, 0);
      queue_value(64'sd1000000000000000000, 1'b1, 13'd19, 0);
      queue_value(64'sh7FFF_FFFF_FFFF_FFFF, 1'b1, 13'd19, 0);
      queue_value(64'sh7FFF_FFFF_FFFF_FFFF, 1'b1, 13'd18, 0);
      queue_value(64'sh8000_0000_0000_0000, 1'b1, 13'd20, 0);
      queue_value(64'sh8000_0000_0000_0000, 1'b1, 13'd19, 0);
      queue_value(64'sh8000_0000_0000_0000, 1'b1, 13'd8191, 0);
      queue_value(64'sh8000_0000_0000_0001, 1'b1, 13'd4097, 0);
      queue_value(64'sd12345, 1'b0, 13'd0, 0);
      queue_value(64'sh8000_0000_0000_0000, 1'b0, 13'd8191, 0);
      queue_value(64'sd0, 1'b0, 13'd4096, 0);
      queue_value(-64'sd9876543210, 1'b1, 13'd11, 0);
      queue_value(64'sh5555_5555_5555_5555, 1'b1, 13'h0AAA, 0);
      queue_value(64'shAAAA_AAAA_AAAA_AAAA, 1'b1, 13'h1555, 0);

      // Random part in four phases of sender behavior: often idle, lightly idle,
      // never idle, and often idle again.
      phase_idle[0] = 59;
      phase_idle[1] = 15;
      phase_idle[2] = 0;
      phase_idle[3] = 59;
      for (int i = 0; i < RANDOM_VALUES; i++) begin
         idle = phase_idle[(i * 4) / RANDOM_VALUES];
         // Shifting a full random word spreads the digit count evenly, and about
         // half of the values are then negated.
         raw = {$urandom, $urandom};
         raw = raw >> $urandom_range(63, 0);
         if ($urandom_range(1, 0) == 1) begin
            raw = ~raw + 64'd1;
         end
         sel = $urandom_range(99, 0);
         ok  = 1'b1;
         if (sel < 10) begin
            ok    = 1'b0;
            space = SPACE_W'($urandom_range(8191, 0));
         end else if (sel < 35) begin
            // Close to the text length, so fits and near misses both show up.
            space = SPACE_W'($urandom_range(21, 0));
         end else begin
            space = SPACE_W'($urandom_range(8191, 20));
         end
         queue_value(raw, ok, space, idle);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      do begin
         @(negedge clock);
      end while (pending_words.size() != 0 || start || due_text_words.size() != 0);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (due_text_words.size() != 0) begin
         report_mismatch($sformatf("%0d words never arrived", due_text_words.size()));
      end

      $display("%0d values taken, %0d words checked, %0d mismatches",
               values_taken, words_checked, mismatch_count);
      $display("%0d texts printed (longest %0d chars), %0d writer failures, %0d no room",
               printed_texts, longest_text, failed_writers, no_room_texts);
      if (mismatch_count == 0) begin
         $display("tb_signed_int_to_decimal_text: done, clean");
      end else begin
         $display("tb_signed_int_to_decimal_text: done, errors");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #(TIMEOUT_UNITS);
      $display("timeout: %0d values taken, %0d words still due",
               values_taken, due_text_words.size());
      $display("tb_signed_int_to_decimal_text: done, errors");
      $finish;
   end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/sidt_pkg.sv
rtl/sidt_front.sv
rtl/sidt_queue.sv
rtl/sidt_back.sv
rtl/signed_int_to_decimal_text.sv
bench/tb_signed_int_to_decimal_text.sv
